### rtl/bwpd_pkg.sv
// Shared types, widths and helpers for the Bezier wire point deformer.
// No dependencies; every other file in rtl/ imports this package.
package bwpd_pkg;

  // Coordinates and packed configuration words
  localparam int CW     = 16;   // Q7.8 coordinate
  localparam int REG_W  = 48;   // packed x/y/z control point
  localparam int REG_N  = 8;    // rest 0..3, warped 0..3
  localparam int IDXW   = 4;    // index port reaches past the register list

  // Curve arithmetic in Q7.16 and the shared multiplier
  localparam int PW     = 24;
  localparam int MAW    = 25;
  localparam int MBW    = 18;
  localparam int MPW    = MAW + MBW;
  localparam int TW     = 17;   // Q0.16 with one guard bit
  localparam int DW     = 34;   // squared distance

  typedef logic signed [PW-1:0]  curve_t;
  typedef logic signed [MAW-1:0] mul_a_t;
  typedef logic signed [MBW-1:0] mul_b_t;
  typedef logic signed [MPW-1:0] mul_p_t;
  typedef logic [TW-1:0]         time_t;
  typedef logic [REG_W-1:0]      cfg_word_t;

  localparam cfg_word_t RESET_FIRST = 48'd16777216;  // (0, 1, 0)
  localparam cfg_word_t RESET_OTHER = 48'd33554432;  // (0, 2, 0)

  // Coordinate c of a packed word, moved to Q7.16.
  function automatic curve_t field_q716(cfg_word_t word, logic [1:0] c);
    logic [CW-1:0] f;
    begin
      case (c)
        2'd0:    f = word[15:0];
        2'd1:    f = word[31:16];
        2'd2:    f = word[47:32];
        default: f = word[15:0];
      endcase
      field_q716 = {f, 8'h00};
    end
  endfunction

endpackage

### rtl/bwpd_mul.sv
// Shared signed multiplier with a registered product.
// Depends on bwpd_pkg for operand and product types.
module bwpd_mul (
  input  logic              clk,
  input  bwpd_pkg::mul_a_t  a,
  input  bwpd_pkg::mul_b_t  b,
  output bwpd_pkg::mul_p_t  prod_r
);
  import bwpd_pkg::*;

  // One product per cycle, registered before any use.
  always_ff @(posedge clk) begin
    prod_r <= MPW'(a) * MPW'(b);
  end

endmodule

### rtl/bwpd_time_step.sv
// Next curve time: t(k+1) from t(k), kept as quotient and remainder of
// (k * 65536 + steps / 2) / steps. Depends on bwpd_pkg for the time type.
module bwpd_time_step #(
  parameter int SEARCH_STEPS = 30
) (
  input  bwpd_pkg::time_t                       t_in,
  input  logic [$clog2(SEARCH_STEPS+1)-1:0]     rem_in,
  output bwpd_pkg::time_t                       t_out,
  output logic [$clog2(SEARCH_STEPS+1)-1:0]     rem_out
);
  import bwpd_pkg::*;

  localparam int RW = $clog2(SEARCH_STEPS + 1);
  localparam time_t          T_STEP = TW'(65536 / SEARCH_STEPS);
  localparam logic [RW:0]    R_STEP = (RW+1)'(65536 % SEARCH_STEPS);
  localparam logic [RW:0]    STEPS  = (RW+1)'(SEARCH_STEPS);

  logic [RW:0] rem_sum;

  // Remainder stays below twice the step count, so one subtract corrects it.
  always_comb begin
    rem_sum = {1'b0, rem_in} + R_STEP;
    if (rem_sum >= STEPS) begin
      rem_out = RW'(rem_sum - STEPS);
      t_out   = t_in + T_STEP + TW'(1);
    end else begin
      rem_out = RW'(rem_sum);
      t_out   = t_in + T_STEP;
    end
  end

endmodule

### rtl/bezier_wire_point_deformer.sv
// Top level of the Bezier wire point deformer: registers, sequencer and
// working set. Depends on bwpd_pkg, bwpd_mul and bwpd_time_step.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   in_x, in_y, in_z
//   out      output     out_valid / out_stall out_x, out_y, out_z,
//                                             out_sample_index, out_best_distance_sq
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// A point is worked through as n evaluations of the rest curve and one of the
// warped curve, each of L = 3 * NUM_POINTS * (NUM_POINTS - 1) / 2 lerps, with n
// the rest curve samples tried: k + 2, or k + 1 when the search ends at the curve
// end. Each lerp is one issue on the single shared multiplier, which also squares
// the distance terms.
// Reset loads the default control points; no clearing pass is needed.
// A waiting result does not block the next transfer in; the block stalls
// its input while a point is being worked on.
module bezier_wire_point_deformer #(
  parameter int NUM_POINTS   = 4,
  parameter int SEARCH_STEPS = 30
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bwpd_pkg::IDXW-1:0]     cfg_index,
  input  bwpd_pkg::cfg_word_t           cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            in_x,
  input  logic signed [15:0]            in_y,
  input  logic signed [15:0]            in_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            out_x,
  output logic signed [15:0]            out_y,
  output logic signed [15:0]            out_z,
  output logic [4:0]                    out_sample_index,
  output logic [bwpd_pkg::DW-1:0]       out_best_distance_sq
);
  import bwpd_pkg::*;

  localparam int KW  = $clog2(SEARCH_STEPS + 1);
  localparam int RW  = $clog2(SEARCH_STEPS + 1);
  localparam int PIW = $clog2(NUM_POINTS);
  localparam int LVW = $clog2(NUM_POINTS + 1);
  localparam logic [KW-1:0]  K_LAST   = KW'(SEARCH_STEPS);
  localparam logic [RW-1:0]  REM_INIT = RW'(SEARCH_STEPS / 2);
  localparam logic [LVW-1:0] LV_INIT  = LVW'(NUM_POINTS);
  localparam time_t          T_ONE    = TW'(65536);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_LERP, S_DRAIN, S_DIST, S_DSUM, S_DECIDE, S_FIN
  } state_t;

  typedef enum logic [1:0] {WB_NONE, WB_LERP, WB_SQ} wb_kind_t;

  state_t        state_r;
  wb_kind_t      wb_kind_r;
  logic [PIW-1:0] wb_i_r;
  logic [1:0]     wb_c_r;

  cfg_word_t     cfg_r [REG_N];
  curve_t        p_r [NUM_POINTS][3];
  curve_t        restp_r [3];
  logic signed [CW-1:0] pt_r [3];

  logic [LVW-1:0] lv_r;
  logic [PIW-1:0] li_r;
  logic [1:0]     lc_r;
  logic           sel_r;
  logic           first_r;

  logic [KW-1:0]  k_r;
  time_t          tk_r, t_eval_r;
  logic [RW-1:0]  rk_r, rem_eval_r;
  logic [DW-1:0]  sum_r, best_r;

  logic                 out_valid_r;
  logic signed [CW-1:0] out_x_r, out_y_r, out_z_r;
  logic [4:0]           out_k_r;
  logic [DW-1:0]        out_d_r;

  mul_a_t  mul_a;
  mul_b_t  mul_b;
  mul_p_t  prod_r;
  time_t   ts_t_in, ts_t_out;
  logic [RW-1:0] ts_r_in, ts_r_out;

  logic signed [MAW-1:0] diff;
  logic signed [MAW-1:0] rnd_tmp;
  logic signed [16:0]    rest_q78;
  logic signed [16:0]    dist_d;
  logic signed [MPW-1:0] prod_rnd;
  curve_t                p_wb;
  logic                  in_take;
  logic                  out_free;
  logic                  improve;
  logic [KW-1:0]         k_adopt;
  logic signed [26:0]    disp [3];
  logic signed [CW-1:0]  sat [3];

  bwpd_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  bwpd_time_step #(.SEARCH_STEPS(SEARCH_STEPS)) u_time (
    .t_in    (ts_t_in),
    .rem_in  (ts_r_in),
    .t_out   (ts_t_out),
    .rem_out (ts_r_out)
  );

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // Operands of the shared multiplier: a lerp difference times t, or a
  // distance term squared.
  always_comb begin
    diff     = MAW'(p_r[PIW'(li_r + 1'b1)][lc_r]) - MAW'(p_r[li_r][lc_r]);
    rnd_tmp  = MAW'(p_r[0][lc_r]) + MAW'(128);
    rest_q78 = rnd_tmp[24:8];
    dist_d   = 17'(MAW'(pt_r[lc_r]) - MAW'(rest_q78));
    if (state_r == S_DIST) begin
      mul_a = MAW'(dist_d);
      mul_b = MBW'(dist_d);
    end else begin
      mul_a = diff;
      mul_b = {1'b0, t_eval_r};
    end
  end

  // Rounded lerp writeback: a + floor((prod + 2^15) / 2^16).
  always_comb begin
    prod_rnd = prod_r + MPW'(32768);
    p_wb     = PW'(MAW'(p_r[wb_i_r][wb_c_r]) + prod_rnd[16 +: MAW]);
  end

  // Search decision and the time of the next candidate sample.
  always_comb begin
    improve = first_r || (sum_r < best_r);
    k_adopt = first_r ? k_r : KW'(k_r + 1'b1);
    ts_t_in = first_r ? tk_r : t_eval_r;
    ts_r_in = first_r ? rk_r : rem_eval_r;
  end

  // Final displacement with saturation to Q7.8.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      disp[c] = 27'($signed({pt_r[c], 8'h00})) + 27'(p_r[0][c]) - 27'(restp_r[c]) + 27'sd128;
      if ($signed(disp[c][26:8]) > 19'sd32767) begin
        sat[c] = 16'sh7FFF;
      end else if ($signed(disp[c][26:8]) < -19'sd32768) begin
        sat[c] = -16'sh8000;
      end else begin
        sat[c] = disp[c][23:8];
      end
    end
  end

  // Configuration registers; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < REG_N; r++) begin
        cfg_r[r] <= ((r % 4) == 0) ? RESET_FIRST : RESET_OTHER;
      end
    end else if (cfg_we && (cfg_index < IDXW'(REG_N))) begin
      cfg_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  // Sequencer and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wb_kind_r   <= WB_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r != S_LERP) && (state_r != S_DIST)) begin
        wb_kind_r <= WB_NONE;
      end
      // A new result in the same cycle as a transfer out keeps valid high.
      if (out_valid_r && !out_stall && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end

      // Results of the previous multiplier issue.
      if (wb_kind_r == WB_LERP) begin
        p_r[wb_i_r][wb_c_r] <= p_wb;
      end else if (wb_kind_r == WB_SQ) begin
        sum_r <= sum_r + prod_r[DW-1:0];
      end

      case (state_r)
        S_IDLE: begin
          if (in_take) begin
            pt_r[0]    <= in_x;
            pt_r[1]    <= in_y;
            pt_r[2]    <= in_z;
            k_r        <= '0;
            tk_r       <= '0;
            rk_r       <= REM_INIT;
            t_eval_r   <= '0;
            rem_eval_r <= REM_INIT;
            first_r    <= 1'b1;
            sel_r      <= 1'b0;
            state_r    <= S_LOAD;
          end
        end
        S_LOAD: begin
          for (int i = 0; i < NUM_POINTS; i++) begin
            for (int c = 0; c < 3; c++) begin
              p_r[i][c] <= field_q716(cfg_r[{sel_r, 2'(i)}], 2'(c));
            end
          end
          lv_r    <= LV_INIT;
          li_r    <= '0;
          lc_r    <= '0;
          state_r <= S_LERP;
        end
        S_LERP: begin
          wb_kind_r <= WB_LERP;
          wb_i_r    <= li_r;
          wb_c_r    <= lc_r;
          if (lc_r == 2'd2) begin
            lc_r <= '0;
            if (li_r == PIW'(lv_r - LVW'(2))) begin
              li_r <= '0;
              if (lv_r == LVW'(2)) begin
                state_r <= S_DRAIN;
              end else begin
                lv_r <= LVW'(lv_r - 1'b1);
              end
            end else begin
              li_r <= PIW'(li_r + 1'b1);
            end
          end else begin
            lc_r <= lc_r + 2'd1;
          end
        end
        S_DRAIN: begin
          sum_r   <= '0;
          lc_r    <= '0;
          state_r <= sel_r ? S_FIN : S_DIST;
        end
        S_DIST: begin
          wb_kind_r <= WB_SQ;
          lc_r      <= lc_r + 2'd1;
          if (lc_r == 2'd2) begin
            state_r <= S_DSUM;
          end
        end
        S_DSUM: begin
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          first_r <= 1'b0;
          if (improve) begin
            best_r <= sum_r;
            for (int c = 0; c < 3; c++) begin
              restp_r[c] <= p_r[0][c];
            end
            if (!first_r) begin
              k_r  <= k_adopt;
              tk_r <= t_eval_r;
              rk_r <= rem_eval_r;
            end
          end
          if (improve && (k_adopt != K_LAST)) begin
            // Try the next sample on the rest curve.
            t_eval_r   <= ts_t_out;
            rem_eval_r <= ts_r_out;
            state_r    <= S_LOAD;
          end else begin
            // Search is over; evaluate the warped curve at the chosen time.
            sel_r    <= 1'b1;
            t_eval_r <= improve ? (first_r ? tk_r : t_eval_r) : tk_r;
            state_r  <= S_LOAD;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_x_r     <= sat[0];
            out_y_r     <= sat[1];
            out_z_r     <= sat[2];
            out_k_r     <= 5'(k_r);
            out_d_r     <= best_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_x                = out_x_r;
  assign out_y                = out_y_r;
  assign out_z                = out_z_r;
  assign out_sample_index     = out_k_r;
  assign out_best_distance_sq = out_d_r;

`ifndef NO_ASSERTIONS
  // The chosen sample never passes the end of the curve.
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (k_r <= K_LAST))
    else $error("sample index past end of curve");

  // Curve time stays within [0, 1] while lerps are issued.
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LERP) |-> (t_eval_r <= T_ONE))
    else $error("curve time above one");

  // A result is withdrawn only after its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(!out_stall))
    else $error("result dropped without transfer");

  // An accepted point starts with a load of the rest control points.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == S_LOAD) && !sel_r && first_r)
    else $error("accepted point did not start an evaluation");
`endif

endmodule

### tb/tb_bezier_wire_point_deformer.sv
// Testbench for the Bezier wire point deformer: directed and random points
// against an in-bench fixed-point curve predictor. Depends on bwpd_pkg.
`timescale 1ns / 1ps

module tb_bezier_wire_point_deformer;
  import bwpd_pkg::*;

  localparam int NPTS  = 4;
  localparam int STEPS = 30;

  // Register indexes.
  typedef enum logic [IDXW-1:0] {
    REG_REST0   = 4'd0,
    REG_REST1   = 4'd1,
    REG_REST2   = 4'd2,
    REG_REST3   = 4'd3,
    REG_WARP0   = 4'd4,
    REG_WARP1   = 4'd5,
    REG_WARP2   = 4'd6,
    REG_WARP3   = 4'd7,
    REG_BAD_LO  = 4'd8,
    REG_BAD_HI  = 4'd15
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [4:0]         k;
    logic [DW-1:0]      dsq;
  } deformed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IDXW-1:0] cfg_index = '0;
  cfg_word_t cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_x = '0, in_y = '0, in_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_x, out_y, out_z;
  logic [4:0] out_sample_index;
  logic [DW-1:0] out_best_distance_sq;

  bezier_wire_point_deformer #(.NUM_POINTS(NPTS), .SEARCH_STEPS(STEPS)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the control point registers.
  cfg_word_t ctrl_pts [8];
  deformed_t expected_points [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  function automatic longint rshift(longint v, int s);
    longint w;
    w = v + (longint'(1) <<< (s - 1));
    if (w >= 0) return w >>> s;
    return -((-w + (longint'(1) <<< s) - 1) >>> s);
  endfunction

  function automatic longint coord(cfg_word_t w, int c);
    logic signed [15:0] f;
    f = w[16*c +: 16];
    return longint'(f);
  endfunction

  // De Casteljau evaluation in Q7.16 for one coordinate.
  function automatic longint curve_at(int base, longint t, int c);
    longint p [NPTS];
    for (int i = 0; i < NPTS; i++) p[i] = coord(ctrl_pts[base + i], c) * 256;
    for (int n = NPTS; n > 1; n--)
      for (int i = 0; i + 1 < n; i++)
        p[i] = p[i] + rshift((p[i + 1] - p[i]) * t, 16);
    return p[0];
  endfunction

  function automatic longint sample_time(int k);
    return (longint'(k) * 65536 + STEPS / 2) / STEPS;
  endfunction

  function automatic longint dist_sq_at(longint pt [3], int k);
    longint sum, d;
    sum = 0;
    for (int c = 0; c < 3; c++) begin
      d = pt[c] - rshift(curve_at(0, sample_time(k), c), 8);
      sum += d * d;
    end
    return sum;
  endfunction

  function automatic deformed_t deform_point(logic signed [15:0] x, logic signed [15:0] y,
                                             logic signed [15:0] z);
    deformed_t r;
    longint pt [3];
    longint best, nd, t, v;
    int k, nk;
    pt[0] = x; pt[1] = y; pt[2] = z;
    k = 0;
    best = dist_sq_at(pt, 0);
    // Greedy walk; a tie or the curve end stops it.
    for (int i = 0; i < STEPS; i++) begin
      nk = (k + 1 > STEPS) ? STEPS : k + 1;
      nd = dist_sq_at(pt, nk);
      if (nd < best) begin
        k = nk;
        best = nd;
      end else begin
        break;
      end
    end
    t = sample_time(k);
    for (int c = 0; c < 3; c++) begin
      v = rshift(pt[c] * 256 + curve_at(4, t, c) - curve_at(0, t, c), 8);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      if (c == 0) r.x = v[15:0];
      else if (c == 1) r.y = v[15:0];
      else r.z = v[15:0];
    end
    r.k = k[4:0];
    r.dsq = best[DW-1:0];
    return r;
  endfunction

  // Sends one point and records its prediction at the transfer. Valid stays
  // high afterwards; the next send, a drain or an idle gap takes it down.
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_points.insert(expected_points.size(), deform_point(x, y, z));
  endtask

  task automatic write_reg(logic [IDXW-1:0] idx, cfg_word_t val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < 8) ctrl_pts[idx] = val;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Receiver stall pattern, with an optional long hold-off.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    deformed_t got, exp_pt;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_x, out_y, out_z, out_sample_index, out_best_distance_sq};
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp_pt = expected_points.pop_front();
        if (got !== exp_pt) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p, actual %p", exp_pt, got);
        end
      end
    end
  end

  function automatic logic signed [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic cfg_word_t rnd_word();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  // A word with modest coordinates, so the search walks well into the curve.
  function automatic cfg_word_t mild_word();
    return {16'($urandom_range(4095) - 2048), 16'($urandom_range(4095) - 2048),
            16'($urandom_range(4095) - 2048)};
  endfunction

  task automatic test_reset_defaults();
    send_point(0, 0, 0);
    send_point(16'h7fff, 16'h7fff, 16'h7fff);
    send_point(16'sh8000, 16'sh8000, 16'sh8000);
    send_point(0, 16'h0200, 0);
    send_point(0, 16'h0180, 0);
    wait_drained();
  endtask

  task automatic test_extremes();
    write_reg(REG_REST0, 48'h0000_0000_0000);
    write_reg(REG_REST1, 48'h0000_0000_7fff);
    write_reg(REG_REST2, 48'h0000_7fff_7fff);
    write_reg(REG_REST3, 48'h7fff_7fff_7fff);
    write_reg(REG_WARP0, 48'h8000_8000_8000);
    write_reg(REG_WARP1, 48'h7fff_7fff_7fff);
    write_reg(REG_WARP2, 48'hffff_ffff_ffff);
    write_reg(REG_WARP3, 48'h8000_8000_8000);
    // Out-of-range indexes are ignored.
    write_reg(REG_BAD_LO, 48'h1234_5678_9abc);
    write_reg(REG_BAD_HI, 48'hffff_ffff_ffff);
    send_point(0, 0, 0);
    send_point(16'h7fff, 16'h7fff, 16'h7fff);
    send_point(16'sh8000, 16'sh8000, 16'sh8000);
    send_point(16'h7fff, 0, 0);
    send_point(16'h4000, 16'h4000, 16'h4000);
    send_point(16'sh8000, 16'h7fff, 16'sh8000);
    wait_drained();
  endtask

  task automatic test_ties_and_end();
    // Flat rest curve: every sample ties, search stops at k = 0.
    for (int i = 0; i < 4; i++) write_reg(reg_idx_e'(REG_REST0 + i), 48'h0000_0100_0000);
    for (int i = 0; i < 4; i++) write_reg(reg_idx_e'(REG_WARP0 + i), mild_word());
    send_point(16'h0100, 16'h0100, 0);
    wait_drained();
    // Straight line along x; a far point drives the search to the curve end.
    write_reg(REG_REST0, 48'h0000_0000_0000);
    write_reg(REG_REST1, 48'h0000_0000_0400);
    write_reg(REG_REST2, 48'h0000_0000_0800);
    write_reg(REG_REST3, 48'h0000_0000_0c00);
    send_point(16'h7fff, 0, 0);
    send_point(16'h0600, 0, 0);
    send_point(16'sh8000, 0, 0);
    wait_drained();
  endtask

  task automatic test_random(int count, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      // Reconfigure between batches of points.
      if (i % 40 == 0) begin
        wait_drained();
        for (int r = 0; r < 8; r++)
          write_reg(reg_idx_e'(r), ($urandom_range(3) == 0) ? rnd_word() : mild_word());
      end
      if ($urandom_range(3) == 0) send_point(rnd16(), rnd16(), rnd16());
      else send_point(16'($urandom_range(8191) - 4096), 16'($urandom_range(8191) - 4096),
                      16'($urandom_range(8191) - 4096));
    end
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    // Long receiver hold-off while points keep coming.
    hold_off_cycles = 3000;
    for (int i = 0; i < 6; i++) send_point(rnd16(), rnd16(), rnd16());
    wait_drained();
    // Sender pause until all results are in, then resume.
    send_point(rnd16(), rnd16(), rnd16());
    wait_drained();
    send_point(rnd16(), rnd16(), rnd16());
    wait_drained();
  endtask

  initial begin
    ctrl_pts[0] = RESET_FIRST;
    ctrl_pts[4] = RESET_FIRST;
    for (int i = 1; i < 4; i++) begin
      ctrl_pts[i] = RESET_OTHER;
      ctrl_pts[i + 4] = RESET_OTHER;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_ties_and_end();
    test_random(240, 0, 0);
    test_random(230, 59, 0);
    test_random(230, 0, 59);
    test_random(215, 16, 16);
    test_backpressure();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_points.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Run limit.
  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
